// ===== src/assert_macros.svh =====
// Assertion macros used by the parser RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ttu_pkg.sv =====
// Shared widths, defaults and types for the text-to-uint16 parser.
// No dependencies.
package ttu_pkg;

  localparam int unsigned CHAR_W          = 8;
  localparam int unsigned VALUE_W         = 16;
  localparam int unsigned CNT_W           = 3;
  localparam int unsigned MAX_DIGITS_DEF  = 4;

  // One registered input byte, handed from the input stage to the parser.
  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] char_byte;
    logic              last_byte;
  } item_t;

endpackage

// ===== src/ttu_in_if.sv =====
// Input channel for the parser: one text byte and its end-of-field mark.
// Depends on ttu_pkg.
interface ttu_in_if
  import ttu_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_byte;
  logic              last_byte;

  modport source (output valid, output char_byte, output last_byte, input ready);
  modport sink   (input valid, input char_byte, input last_byte, output ready);
endinterface

// ===== src/ttu_out_if.sv =====
// Result channel for the parser: success flag and parsed value.
// Depends on ttu_pkg.
interface ttu_out_if
  import ttu_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               parse_ok;
  logic [VALUE_W-1:0] number_value;

  modport source (output valid, output parse_ok, output number_value, input ready);
  modport sink   (input valid, input parse_ok, input number_value, output ready);
endinterface

// ===== src/ttu_in_reg.sv =====
// Input register of the parser: holds one accepted byte until the parser takes it.
// Depends on ttu_pkg.
module ttu_in_reg
  import ttu_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [CHAR_W-1:0] char_byte_i,
  input  logic              last_byte_i,
  output logic              ready_o,
  input  logic              take_i,
  output item_t             item_o
);

  logic              valid_q;
  logic [CHAR_W-1:0] char_q;
  logic              last_q;

  // Accept when empty or when the held byte leaves this cycle
  assign ready_o = !valid_q || take_i;

  // Hold valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Capture payload on each transaction
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      char_q <= char_byte_i;
      last_q <= last_byte_i;
    end
  end

  assign item_o = '{valid: valid_q, char_byte: char_q, last_byte: last_q};

endmodule

// ===== src/ttu_parse.sv =====
// Parser step: phase, digit count and value registers, plus the result register.
// Depends on ttu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ttu_parse
  import ttu_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  item_t              item_i,
  output logic               take_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               parse_ok_o,
  output logic [VALUE_W-1:0] number_value_o
);

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_ZERO,
    PH_DEC,
    PH_HEX,
    PH_DONE
  } phase_e;

  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_F    = 8'h46;
  localparam logic [CHAR_W-1:0] CH_UP_X    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LO_A    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_X    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LO_Z    = 8'h7a;
  localparam logic [CHAR_W-1:0] CASE_DIFF  = 8'd32;
  localparam logic [CHAR_W-1:0] HEX_OFFSET = 8'h0a;
  localparam logic [CNT_W-1:0]  CNT_MAX    = CNT_W'(MAX_DIGITS);

  phase_e             phase_q, phase_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [VALUE_W-1:0] acc_q, acc_d;
  logic               out_valid_q;
  logic               ok_q;
  logic [VALUE_W-1:0] val_q;

  logic [CHAR_W-1:0]  c;
  logic [CHAR_W-1:0]  c_up;
  logic               is_dec;
  logic               is_hex_letter;
  logic [3:0]         dec_digit;
  logic [3:0]         hex_digit;
  logic               room;
  logic [VALUE_W-1:0] acc_dec;
  logic [VALUE_W-1:0] acc_hex;
  logic [VALUE_W-1:0] acc_from_dec;
  logic               out_free;

  // Advance the held byte when it makes no result or the result register frees up
  assign out_free = !out_valid_q || out_ready_i;
  assign take_o   = item_i.valid && (!item_i.last_byte || out_free);

  // Classify the byte
  assign c             = item_i.char_byte;
  assign c_up          = (c >= CH_LO_A && c <= CH_LO_Z) ? c - CASE_DIFF : c;
  assign is_dec        = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_hex_letter = (c_up >= CH_UP_A) && (c_up <= CH_UP_F);
  assign dec_digit     = 4'(c - CH_ZERO);
  assign hex_digit     = (c_up >= CH_UP_A) ? 4'(c_up - CH_UP_A + HEX_OFFSET)
                                           : 4'(c_up - CH_ZERO);
  assign room          = cnt_q < CNT_MAX;

  // Shift-add updates: times ten for decimal, times sixteen for hex
  assign acc_dec = (acc_q << 3) + (acc_q << 1) + VALUE_W'(dec_digit);
  assign acc_hex = (acc_q << 4) + VALUE_W'(hex_digit);
  // A decimal digit after a lone leading zero starts from zero
  assign acc_from_dec = acc_dec;

  // Next parse state for the held byte
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    unique case (phase_q)
      PH_SKIP: begin
        if (c == CH_SPACE) begin
          phase_d = PH_SKIP;
        end else if (c == CH_ZERO) begin
          phase_d = PH_ZERO;
          acc_d   = '0;
          cnt_d   = CNT_W'(1);
        end else if (room && is_dec) begin
          phase_d = PH_DEC;
          acc_d   = acc_from_dec;
          cnt_d   = cnt_q + CNT_W'(1);
        end else begin
          phase_d = PH_DONE;
        end
      end
      PH_ZERO: begin
        if (c == CH_UP_X || c == CH_LO_X) begin
          phase_d = PH_HEX;
          acc_d   = '0;
          cnt_d   = '0;
        end else if (room && is_dec) begin
          phase_d = PH_DEC;
          acc_d   = acc_from_dec;
          cnt_d   = cnt_q + CNT_W'(1);
        end else begin
          phase_d = PH_DONE;
        end
      end
      PH_DEC: begin
        if (room && is_dec) begin
          acc_d = acc_dec;
          cnt_d = cnt_q + CNT_W'(1);
        end else begin
          phase_d = PH_DONE;
        end
      end
      PH_HEX: begin
        if (room && (is_dec || is_hex_letter)) begin
          acc_d = acc_hex;
          cnt_d = cnt_q + CNT_W'(1);
        end else begin
          phase_d = PH_DONE;
        end
      end
      default: begin
        phase_d = PH_DONE;
      end
    endcase
  end

  // Hold parse state and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SKIP;
      cnt_q       <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      val_q       <= '0;
    end else begin
      // Raise result valid on a last byte, drop it once the result is taken
      if (take_o && item_i.last_byte) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (take_o) begin
        if (item_i.last_byte) begin
          // Emit the result and drop back to the start of a field
          ok_q        <= (cnt_d != '0);
          val_q       <= (cnt_d != '0) ? acc_d : '0;
          phase_q     <= PH_SKIP;
          cnt_q       <= '0;
          acc_q       <= '0;
        end else begin
          phase_q <= phase_d;
          cnt_q   <= cnt_d;
          acc_q   <= acc_d;
        end
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign parse_ok_o     = ok_q;
  assign number_value_o = val_q;

  `ASSERT_IMPLIES(a_fail_is_zero, out_valid_q && !ok_q, val_q == '0,
                  "failed parse carries a nonzero value")
  `ASSERT_ALWAYS(a_cnt_limit, cnt_q <= CNT_MAX, "digit count above limit")
  `ASSERT_NEXT(a_field_restart, take_o && item_i.last_byte,
               phase_q == PH_SKIP && cnt_q == '0 && acc_q == '0,
               "state not cleared after end of field")
  `ASSERT_NEXT(a_result_held, out_valid_q && !out_ready_i,
               out_valid_q && $stable(val_q) && $stable(ok_q),
               "pending result lost or changed while stalled")

endmodule

// ===== src/text_to_uint16_parser.sv =====
// Top level of the text-to-uint16 parser: input register feeding the parse step.
// Depends on ttu_pkg, ttu_in_if, ttu_out_if, ttu_in_reg and ttu_parse.
//
// Channel | Dir | Payload                       | Transactions
// in_i    | in  | char_byte[7:0], last_byte     | one per text byte
// out_o   | out | parse_ok, number_value[15:0]  | one per byte with last_byte set
//
// Each byte passes the input register, then the parse step and its result register;
// a new byte is accepted every cycle unless a byte marked last is held for out_o.
// The parse step takes a byte marked last only when the result register is empty or out_o takes it;
// other bytes pass even while a result waits.
// Reset clears the input register, parse state and result valid asynchronously.
module text_to_uint16_parser
  import ttu_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ttu_in_if.sink    in_i,
  ttu_out_if.source out_o
);

  item_t item;
  logic  take;

  // Register incoming bytes
  ttu_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_i.valid),
    .char_byte_i (in_i.char_byte),
    .last_byte_i (in_i.last_byte),
    .ready_o     (in_i.ready),
    .take_i      (take),
    .item_o      (item)
  );

  // Parse and register results
  ttu_parse #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item),
    .take_o         (take),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .parse_ok_o     (out_o.parse_ok),
    .number_value_o (out_o.number_value)
  );

endmodule
